/* hdl/edts_pkg.sv */
// shared types, codes and constants for the exact dot-product top-k search unit
// no dependencies

package edts_pkg;

   localparam int unsigned MAX_ROWS_DEF = 1024;
   localparam int unsigned MAX_DIM_DEF  = 256;
   localparam int unsigned MAX_K_DEF    = 16;

   localparam int unsigned KEY_W     = 16;
   localparam int unsigned VAL_W     = 16;
   localparam int unsigned SCORE_W   = 36;
   localparam int unsigned SSUM_W    = 40;
   localparam int unsigned PROD_W    = 2 * VAL_W;
   localparam int unsigned FRAC_BITS = 14;

   // item op codes
   localparam logic [2:0] OP_BEGIN = 3'd0;
   localparam logic [2:0] OP_ELEM  = 3'd1;
   localparam logic [2:0] OP_END   = 3'd2;
   localparam logic [2:0] OP_ALLOW = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   // result status codes
   localparam logic [2:0] ST_CAND    = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_BUILT   = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_DUP     = 3'd4;
   localparam logic [2:0] ST_DIM     = 3'd5;

   localparam logic [SSUM_W-1:0] ONE_SQ   = SSUM_W'(64'd1 << (2 * FRAC_BITS));
   localparam logic [SSUM_W-1:0] NORM_TOL = ONE_SQ / 1000;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef struct packed {
      logic [2:0]              op;
      logic [KEY_W-1:0]        key_id;
      logic signed [VAL_W-1:0] value;
      logic                    end_of_vector;
      logic [4:0]              k;
   } req_type;

   typedef struct packed {
      logic [2:0]                status;
      logic [KEY_W-1:0]          key_id_res;
      logic signed [SCORE_W-1:0] score;
      logic                      last;
   } rsp_type;

   // squared norm within tolerance of one
   function automatic logic norm_ok(input logic [SSUM_W-1:0] sum);
      logic [SSUM_W-1:0] d;
      begin
         d = (sum > ONE_SQ) ? (sum - ONE_SQ) : (ONE_SQ - sum);
         return d <= NORM_TOL;
      end
   endfunction

endpackage

/* hdl/edts_store.sv */
// synchronous memories: vector table, key table, allow bits and query buffer
// depends on edts_pkg

module edts_store #(
   parameter int unsigned MAX_ROWS = edts_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_DIM  = edts_pkg::MAX_DIM_DEF,
   parameter int unsigned RA_W     = 10,
   parameter int unsigned DA_W     = 8,
   parameter int unsigned VA_W     = 18
) (
   input  logic                            clock,
   input  logic                            vec_we,
   input  logic [VA_W-1:0]                 vec_waddr,
   input  logic [edts_pkg::VAL_W-1:0]      vec_wdata,
   input  logic [VA_W-1:0]                 vec_raddr,
   output logic [edts_pkg::VAL_W-1:0]      vec_rdata,
   input  logic                            key_we,
   input  logic [RA_W-1:0]                 key_waddr,
   input  logic [edts_pkg::KEY_W-1:0]      key_wdata,
   input  logic [RA_W-1:0]                 key_raddr,
   output logic [edts_pkg::KEY_W-1:0]      key_rdata,
   input  logic                            alw_we,
   input  logic [RA_W-1:0]                 alw_waddr,
   input  logic                            alw_wdata,
   input  logic [RA_W-1:0]                 alw_raddr,
   output logic                            alw_rdata,
   input  logic                            qb_we,
   input  logic [DA_W-1:0]                 qb_waddr,
   input  logic [edts_pkg::VAL_W-1:0]      qb_wdata,
   input  logic [DA_W-1:0]                 qb_raddr,
   output logic [edts_pkg::VAL_W-1:0]      qb_rdata
);

   logic [edts_pkg::VAL_W-1:0] vec_mem [MAX_ROWS*MAX_DIM];
   logic [edts_pkg::KEY_W-1:0] key_mem [MAX_ROWS];
   logic                       alw_mem [MAX_ROWS];
   logic [edts_pkg::VAL_W-1:0] qb_mem  [MAX_DIM];

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_waddr] <= vec_wdata;
      end
      vec_rdata <= vec_mem[vec_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rdata <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (alw_we) begin
         alw_mem[alw_waddr] <= alw_wdata;
      end
      alw_rdata <= alw_mem[alw_raddr];
   end

   always_ff @(posedge clock) begin
      if (qb_we) begin
         qb_mem[qb_waddr] <= qb_wdata;
      end
      qb_rdata <= qb_mem[qb_raddr];
   end

endmodule

/* hdl/edts_topk.sv */
// sorted best-k list, one insertion per cycle, descending score, lower key wins ties
// depends on edts_pkg

module edts_topk #(
   parameter int unsigned MAX_K = edts_pkg::MAX_K_DEF,
   parameter int unsigned KC_W  = 5,
   parameter int unsigned KA_W  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                ins_valid,
   input  logic signed [edts_pkg::SCORE_W-1:0] ins_score,
   input  logic [edts_pkg::KEY_W-1:0]          ins_key,
   input  logic [KC_W-1:0]                     kk,
   input  logic [KA_W-1:0]                     rd_idx,
   output logic [edts_pkg::KEY_W-1:0]          rd_key,
   output logic signed [edts_pkg::SCORE_W-1:0] rd_score,
   output logic [KC_W-1:0]                     found
);

   logic [edts_pkg::KEY_W-1:0]          best_key_ff   [MAX_K];
   logic [edts_pkg::KEY_W-1:0]          best_key_in   [MAX_K];
   logic signed [edts_pkg::SCORE_W-1:0] best_score_ff [MAX_K];
   logic signed [edts_pkg::SCORE_W-1:0] best_score_in [MAX_K];
   logic [KC_W-1:0]                     found_ff, found_in;
   logic [MAX_K-1:0]                    keep;
   logic                                do_ins;

   always_comb begin
      do_ins = 1'b0;
      for (int i = 0; i < MAX_K; i++) begin
         // an entry stays put when it is valid and beats the newcomer
         keep[i] = (KC_W'(i) < found_ff) &&
                   !((ins_score > best_score_ff[i]) ||
                     ((ins_score == best_score_ff[i]) && (ins_key < best_key_ff[i])));
         if ((KC_W'(i) < kk) && !keep[i]) begin
            do_ins = 1'b1;
         end
      end

      best_key_in[0]   = keep[0] ? best_key_ff[0]   : ins_key;
      best_score_in[0] = keep[0] ? best_score_ff[0] : ins_score;
      for (int i = 1; i < MAX_K; i++) begin
         if (keep[i]) begin
            best_key_in[i]   = best_key_ff[i];
            best_score_in[i] = best_score_ff[i];
         end else if (keep[i-1]) begin
            best_key_in[i]   = ins_key;
            best_score_in[i] = ins_score;
         end else begin
            best_key_in[i]   = best_key_ff[i-1];
            best_score_in[i] = best_score_ff[i-1];
         end
      end

      found_in = found_ff;
      if (clear) begin
         found_in = '0;
      end else if (ins_valid && do_ins && (found_ff < kk)) begin
         found_in = found_ff + KC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_valid && do_ins) begin
         best_key_ff   <= best_key_in;
         best_score_ff <= best_score_in;
      end
   end

   assign rd_key   = best_key_ff[rd_idx];
   assign rd_score = best_score_ff[rd_idx];
   assign found    = found_ff;

endmodule

/* hdl/exact_dot_topk_search_unit.sv */
// top level of the exact dot-product top-k search unit: sequencer, dot-product datapath
// depends on edts_pkg, edts_store, edts_topk

// Items are taken one at a time. Begin build, an allow item inside a build or
// against an empty index, and vector and query elements that do not close a row
// leave the sequencer idle. An element closing a row walks the key table through
// its single read port for the duplicate check; an allow item outside a build
// with rows held walks it in the same way. End build waits for the result
// register. The last query element scores every permitted row, through the one
// read port of the vector table feeding one multiplier, then sends the result
// items or a status item, then clears the allow bits.
// There is no clearing pass after reset: allow bits are written to zero as each
// row is added, so only rows already in the table are ever read.

module exact_dot_topk_search_unit #(
   parameter int unsigned MAX_ROWS = edts_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_DIM  = edts_pkg::MAX_DIM_DEF,
   parameter int unsigned MAX_K    = edts_pkg::MAX_K_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  edts_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output edts_pkg::rsp_type rsp_item
);

   localparam int unsigned RC_W   = $clog2(MAX_ROWS + 1);
   localparam int unsigned RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned DC_W   = $clog2(MAX_DIM + 2);
   localparam int unsigned DA_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned VDEPTH = MAX_ROWS * MAX_DIM;
   localparam int unsigned VA_W   = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
   localparam int unsigned KC_W   = $clog2(MAX_K + 1);
   localparam int unsigned KA_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int unsigned ACC_W  = edts_pkg::PROD_W + $clog2(MAX_DIM + 1);
   localparam int unsigned EXT_W  = (ACC_W > edts_pkg::SCORE_W) ? ACC_W : edts_pkg::SCORE_W;
   localparam int unsigned KEY_W  = edts_pkg::KEY_W;
   localparam int unsigned VAL_W  = edts_pkg::VAL_W;
   localparam int unsigned SSUM_W = edts_pkg::SSUM_W;
   localparam int unsigned PROD_W = edts_pkg::PROD_W;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DUP    = 4'd1;
   localparam logic [3:0] S_ALLOW  = 4'd2;
   localparam logic [3:0] S_QBEGIN = 4'd3;
   localparam logic [3:0] S_QROW   = 4'd4;
   localparam logic [3:0] S_QCHK   = 4'd5;
   localparam logic [3:0] S_MAC    = 4'd6;
   localparam logic [3:0] S_INS    = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;
   localparam logic [3:0] S_CLR    = 4'd10;

   // control state
   logic [3:0]       state_ff, state_in;
   logic             building_ff, building_in;
   logic [2:0]       build_err_ff, build_err_in;
   logic [RC_W-1:0]  rc_ff, rc_in;
   logic [DC_W-1:0]  dim_ff, dim_in;
   logic [DC_W-1:0]  ec_ff, ec_in;
   logic [SSUM_W-1:0] ssum_ff, ssum_in;
   logic [DC_W-1:0]  qc_ff, qc_in;
   logic [DC_W-1:0]  qlen_ff, qlen_in;
   logic [SSUM_W-1:0] qsum_ff, qsum_in;
   logic             any_alw_ff, any_alw_in;
   logic [VA_W:0]    base_ff, base_in;
   logic [RC_W-1:0]  scan_ff, scan_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [DC_W-1:0]  mac_i_ff, mac_i_in;
   logic             m1_ff, m1_in;
   logic             m2_ff, m2_in;
   logic [KC_W-1:0]  out_i_ff, out_i_in;
   logic             emit_clr_ff, emit_clr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [RA_W-1:0]               rd_row_ff, rd_row_in;
   logic [KEY_W-1:0]              cur_key_ff, cur_key_in;
   logic [KEY_W-1:0]              row_key_ff, row_key_in;
   logic [KC_W-1:0]               kk_ff, kk_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [2:0]                    pend_st_ff, pend_st_in;
   logic [KEY_W-1:0]              pend_key_ff, pend_key_in;
   edts_pkg::rsp_type             rsp_ff, rsp_in;

   // memory ports
   logic              vec_we, key_we, alw_we, alw_wdata, qb_we;
   logic [VA_W-1:0]   vec_waddr, vec_raddr;
   logic [VAL_W-1:0]  vec_rdata, qb_rdata;
   logic [KEY_W-1:0]  key_rdata;
   logic              alw_rdata;
   logic [RA_W-1:0]   alw_waddr;
   logic [VA_W:0]     vec_wsum, vec_rsum;

   // best-k list
   logic                                tk_clear, tk_ins;
   logic [KEY_W-1:0]                    tk_key;
   logic signed [edts_pkg::SCORE_W-1:0] tk_score;
   logic [KC_W-1:0]                     tk_found;
   logic signed [edts_pkg::SCORE_W-1:0] sat_score;
   logic signed [EXT_W-1:0]             acc_x;

   logic signed [PROD_W-1:0] sq;
   logic                     accept, out_free;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // element square for the running norm
   assign sq = $signed(req_item.value) * $signed(req_item.value);

   assign vec_wsum  = base_ff + (VA_W+1)'(ec_ff);
   assign vec_rsum  = base_ff + (VA_W+1)'(mac_i_ff);
   assign vec_waddr = vec_wsum[VA_W-1:0];
   assign vec_raddr = vec_rsum[VA_W-1:0];

   // score saturated to the result width
   always_comb begin
      acc_x = EXT_W'(acc_ff);
      if (acc_x > EXT_W'(edts_pkg::SCORE_MAX)) begin
         sat_score = edts_pkg::SCORE_MAX;
      end else if (acc_x < EXT_W'(edts_pkg::SCORE_MIN)) begin
         sat_score = edts_pkg::SCORE_MIN;
      end else begin
         sat_score = edts_pkg::SCORE_W'(acc_x);
      end
   end

   always_comb begin
      state_in     = state_ff;
      building_in  = building_ff;
      build_err_in = build_err_ff;
      rc_in        = rc_ff;
      dim_in       = dim_ff;
      ec_in        = ec_ff;
      ssum_in      = ssum_ff;
      qc_in        = qc_ff;
      qlen_in      = qlen_ff;
      qsum_in      = qsum_ff;
      any_alw_in   = any_alw_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      mac_i_in     = mac_i_ff;
      m1_in        = 1'b0;
      m2_in        = m1_ff;
      out_i_in     = out_i_ff;
      emit_clr_in  = emit_clr_ff;
      rd_row_in    = scan_ff[RA_W-1:0];
      cur_key_in   = cur_key_ff;
      row_key_in   = row_key_ff;
      kk_in        = kk_ff;
      prod_in      = $signed(qb_rdata) * $signed(vec_rdata);
      acc_in       = acc_ff;
      pend_st_in   = pend_st_ff;
      pend_key_in  = pend_key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vec_we       = 1'b0;
      key_we       = 1'b0;
      alw_we       = 1'b0;
      alw_wdata    = 1'b0;
      alw_waddr    = scan_ff[RA_W-1:0];
      qb_we        = 1'b0;
      tk_clear     = 1'b0;
      tk_ins       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_item.op)
                  edts_pkg::OP_BEGIN: begin
                     building_in  = 1'b1;
                     rc_in        = '0;
                     dim_in       = '0;
                     ec_in        = '0;
                     build_err_in = '0;
                     ssum_in      = '0;
                     any_alw_in   = 1'b0;
                     base_in      = '0;
                  end
                  edts_pkg::OP_ELEM: begin
                     if (building_ff && (build_err_ff == '0)) begin
                        vec_we  = (ec_ff < DC_W'(MAX_DIM)) && (rc_ff < RC_W'(MAX_ROWS));
                        ssum_in = ssum_ff + SSUM_W'($unsigned(sq));
                        if (ec_ff <= DC_W'(MAX_DIM)) begin
                           ec_in = ec_ff + DC_W'(1);
                        end
                        if (req_item.end_of_vector) begin
                           // table full or empty key fail at once
                           if ((rc_ff >= RC_W'(MAX_ROWS)) || (req_item.key_id == '0)) begin
                              build_err_in = edts_pkg::ST_INVALID;
                              ec_in        = '0;
                              ssum_in      = '0;
                           end else begin
                              cur_key_in = req_item.key_id;
                              scan_in    = '0;
                              state_in   = S_DUP;
                           end
                        end
                     end
                  end
                  edts_pkg::OP_END: begin
                     pend_key_in = '0;
                     emit_clr_in = 1'b0;
                     state_in    = S_EMIT;
                     if (!building_ff) begin
                        pend_st_in = edts_pkg::ST_INVALID;
                     end else begin
                        building_in  = 1'b0;
                        ec_in        = '0;
                        ssum_in      = '0;
                        build_err_in = '0;
                        if ((build_err_ff != '0) || (ec_ff != '0)) begin
                           pend_st_in = (build_err_ff != '0) ? build_err_ff : edts_pkg::ST_DIM;
                           rc_in      = '0;
                           dim_in     = '0;
                        end else begin
                           pend_st_in  = edts_pkg::ST_BUILT;
                           pend_key_in = KEY_W'(rc_ff);
                        end
                     end
                  end
                  edts_pkg::OP_ALLOW: begin
                     any_alw_in = 1'b1;
                     if (!building_ff && (rc_ff != '0)) begin
                        cur_key_in = req_item.key_id;
                        scan_in    = '0;
                        state_in   = S_ALLOW;
                     end
                  end
                  edts_pkg::OP_QUERY: begin
                     if (qc_ff < DC_W'(MAX_DIM)) begin
                        qb_we   = 1'b1;
                        qsum_in = qsum_ff + SSUM_W'($unsigned(sq));
                     end
                     if (qc_ff <= DC_W'(MAX_DIM)) begin
                        qc_in = qc_ff + DC_W'(1);
                     end
                     if (req_item.end_of_vector) begin
                        qlen_in = (qc_ff <= DC_W'(MAX_DIM)) ? (qc_ff + DC_W'(1)) : qc_ff;
                        qc_in   = '0;
                        kk_in   = (32'(req_item.k) > MAX_K) ? KC_W'(MAX_K) : KC_W'(req_item.k);
                        state_in = S_QBEGIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_DUP: begin
            // walk the key table, compare in the cycle after the read
            if (scan_ff < rc_ff) begin
               scan_in   = scan_ff + RC_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && (key_rdata == cur_key_ff)) begin
               build_err_in = edts_pkg::ST_DUP;
               ec_in        = '0;
               ssum_in      = '0;
               rd_vld_in    = 1'b0;
               state_in     = S_IDLE;
            end else if ((scan_ff == rc_ff) && !rd_vld_ff) begin
               ec_in    = '0;
               ssum_in  = '0;
               state_in = S_IDLE;
               if ((ec_ff > DC_W'(MAX_DIM)) || ((rc_ff != '0) && (ec_ff != dim_ff))) begin
                  build_err_in = edts_pkg::ST_DIM;
               end else if (!edts_pkg::norm_ok(ssum_ff)) begin
                  build_err_in = edts_pkg::ST_INVALID;
               end else begin
                  // row accepted: key in, allow bit cleared
                  key_we    = 1'b1;
                  alw_we    = 1'b1;
                  alw_wdata = 1'b0;
                  alw_waddr = rc_ff[RA_W-1:0];
                  rc_in     = rc_ff + RC_W'(1);
                  base_in   = base_ff + (VA_W+1)'(MAX_DIM);
                  if (rc_ff == '0) begin
                     dim_in = ec_ff;
                  end
               end
            end
         end

         S_ALLOW: begin
            if (scan_ff < rc_ff) begin
               scan_in   = scan_ff + RC_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && (key_rdata == cur_key_ff)) begin
               alw_we    = 1'b1;
               alw_wdata = 1'b1;
               alw_waddr = rd_row_ff;
            end
            if ((scan_ff == rc_ff) && !rd_vld_ff) begin
               state_in = S_IDLE;
            end
         end

         S_QBEGIN: begin
            qsum_in     = '0;
            pend_key_in = '0;
            emit_clr_in = 1'b1;
            if ((kk_ff == '0) || building_ff || (rc_ff == '0)) begin
               pend_st_in = edts_pkg::ST_EMPTY;
               state_in   = S_EMIT;
            end else if (qlen_ff != dim_ff) begin
               pend_st_in = edts_pkg::ST_DIM;
               state_in   = S_EMIT;
            end else if (!edts_pkg::norm_ok(qsum_ff)) begin
               pend_st_in = edts_pkg::ST_INVALID;
               state_in   = S_EMIT;
            end else begin
               tk_clear = 1'b1;
               scan_in  = '0;
               base_in  = '0;
               state_in = S_QROW;
            end
         end

         S_QROW: begin
            // key and allow bit of row scan_ff are being read
            if (scan_ff == rc_ff) begin
               if (tk_found == '0) begin
                  pend_st_in  = edts_pkg::ST_EMPTY;
                  pend_key_in = '0;
                  state_in    = S_EMIT;
               end else begin
                  out_i_in = '0;
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_QCHK;
            end
         end

         S_QCHK: begin
            if (any_alw_ff && !alw_rdata) begin
               scan_in  = scan_ff + RC_W'(1);
               base_in  = base_ff + (VA_W+1)'(MAX_DIM);
               state_in = S_QROW;
            end else begin
               row_key_in = key_rdata;
               mac_i_in   = '0;
               acc_in     = '0;
               state_in   = S_MAC;
            end
         end

         S_MAC: begin
            // read, multiply, accumulate: one element per cycle
            if (mac_i_ff < dim_ff) begin
               mac_i_in = mac_i_ff + DC_W'(1);
               m1_in    = 1'b1;
            end
            if (m2_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if ((mac_i_ff == dim_ff) && !m1_ff && !m2_ff) begin
               state_in = S_INS;
            end
         end

         S_INS: begin
            tk_ins   = 1'b1;
            scan_in  = scan_ff + RC_W'(1);
            base_in  = base_ff + (VA_W+1)'(MAX_DIM);
            state_in = S_QROW;
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = edts_pkg::ST_CAND;
               rsp_in.key_id_res  = tk_key;
               rsp_in.score       = tk_score;
               rsp_in.last        = ((out_i_ff + KC_W'(1)) == tk_found);
               out_i_in           = out_i_ff + KC_W'(1);
               if ((out_i_ff + KC_W'(1)) == tk_found) begin
                  scan_in  = '0;
                  state_in = S_CLR;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = pend_st_ff;
               rsp_in.key_id_res = pend_key_ff;
               rsp_in.score      = '0;
               rsp_in.last       = 1'b1;
               scan_in           = '0;
               state_in          = emit_clr_ff ? S_CLR : S_IDLE;
            end
         end

         S_CLR: begin
            // allow set ends with the query
            if (scan_ff < rc_ff) begin
               alw_we    = 1'b1;
               alw_wdata = 1'b0;
               scan_in   = scan_ff + RC_W'(1);
            end else begin
               any_alw_in = 1'b0;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         building_ff  <= 1'b0;
         build_err_ff <= '0;
         rc_ff        <= '0;
         dim_ff       <= '0;
         ec_ff        <= '0;
         ssum_ff      <= '0;
         qc_ff        <= '0;
         qlen_ff      <= '0;
         qsum_ff      <= '0;
         any_alw_ff   <= 1'b0;
         base_ff      <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         mac_i_ff     <= '0;
         m1_ff        <= 1'b0;
         m2_ff        <= 1'b0;
         out_i_ff     <= '0;
         emit_clr_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         building_ff  <= building_in;
         build_err_ff <= build_err_in;
         rc_ff        <= rc_in;
         dim_ff       <= dim_in;
         ec_ff        <= ec_in;
         ssum_ff      <= ssum_in;
         qc_ff        <= qc_in;
         qlen_ff      <= qlen_in;
         qsum_ff      <= qsum_in;
         any_alw_ff   <= any_alw_in;
         base_ff      <= base_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         mac_i_ff     <= mac_i_in;
         m1_ff        <= m1_in;
         m2_ff        <= m2_in;
         out_i_ff     <= out_i_in;
         emit_clr_ff  <= emit_clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_row_ff   <= rd_row_in;
      cur_key_ff  <= cur_key_in;
      row_key_ff  <= row_key_in;
      kk_ff       <= kk_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      pend_st_ff  <= pend_st_in;
      pend_key_ff <= pend_key_in;
      rsp_ff      <= rsp_in;
   end

   edts_store #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_DIM  (MAX_DIM),
      .RA_W     (RA_W),
      .DA_W     (DA_W),
      .VA_W     (VA_W)
   ) u_store (
      .clock     (clock),
      .vec_we    (vec_we),
      .vec_waddr (vec_waddr),
      .vec_wdata (req_item.value),
      .vec_raddr (vec_raddr),
      .vec_rdata (vec_rdata),
      .key_we    (key_we),
      .key_waddr (rc_ff[RA_W-1:0]),
      .key_wdata (cur_key_ff),
      .key_raddr (scan_ff[RA_W-1:0]),
      .key_rdata (key_rdata),
      .alw_we    (alw_we),
      .alw_waddr (alw_waddr),
      .alw_wdata (alw_wdata),
      .alw_raddr (scan_ff[RA_W-1:0]),
      .alw_rdata (alw_rdata),
      .qb_we     (qb_we),
      .qb_waddr  (qc_ff[DA_W-1:0]),
      .qb_wdata  (req_item.value),
      .qb_raddr  (mac_i_ff[DA_W-1:0]),
      .qb_rdata  (qb_rdata)
   );

   edts_topk #(
      .MAX_K (MAX_K),
      .KC_W  (KC_W),
      .KA_W  (KA_W)
   ) u_topk (
      .clock     (clock),
      .reset     (reset),
      .clear     (tk_clear),
      .ins_valid (tk_ins),
      .ins_score (sat_score),
      .ins_key   (row_key_ff),
      .kk        (kk_ff),
      .rd_idx    (out_i_ff[KA_W-1:0]),
      .rd_key    (tk_key),
      .rd_score  (tk_score),
      .found     (tk_found)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hdl/edts_sva.sv */
// port-level checker for the exact dot-product top-k search unit, bound to the top level
// depends on edts_pkg and exact_dot_topk_search_unit

module edts_sva (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input edts_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input edts_pkg::rsp_type rsp_item
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // status results stand alone
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != edts_pkg::ST_CAND) |-> rsp_item.last)
      else $error("status result not marked last");

   a_status_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != edts_pkg::ST_CAND) |-> (rsp_item.score == '0))
      else $error("status result with non-zero score");

   // end build always owes a result, so the next item waits
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.op == edts_pkg::OP_END) |=> !req_ready)
      else $error("item taken while end build result pending");

endmodule

bind exact_dot_topk_search_unit edts_sva u_edts_sva (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

/* sim/exact_dot_topk_search_unit_tb.sv */
// self-checking testbench for exact_dot_topk_search_unit: index builds, allow lists, top-k queries
// depends on edts_pkg and the rtl of the search unit; a class predicts every result item
`timescale 1ns / 100ps

module exact_dot_topk_search_unit_tb;

   localparam int N_ROWS      = 1024;
   localparam int N_DIM       = 256;
   localparam int N_K         = 16;
   localparam int CYCLE_CAP   = 600000;
   localparam int ITEM_TARGET = 100;

   // predicted state of the block plus the queue of result items still owed
   class topk_tracker;
      bit [15:0]         vstore [N_ROWS*N_DIM];
      bit [15:0]         keys [N_ROWS];
      bit                allowed [N_ROWS];
      bit                any_allowed;
      int                rows, dim, elems, qcount;
      logic [2:0]        berr;
      longint            sqsum;
      bit [15:0]         qbuf [N_DIM];
      bit                building;
      edts_pkg::rsp_type owed_hits [$];
      int                errors;

      function new();
         rows = 0; dim = 0; elems = 0; qcount = 0; berr = 0; sqsum = 0;
         building = 0; errors = 0;
         clear_allow();
      endfunction

      function void clear_allow();
         foreach (allowed[i]) allowed[i] = 0;
         any_allowed = 0;
      endfunction

      function bit unit_norm(longint s);
         longint d;
         d = (s > 64'sd268435456) ? s - 64'sd268435456 : 64'sd268435456 - s;
         return d <= 64'sd268435;
      endfunction

      function void emit(logic [2:0] st, logic [15:0] key, longint sc, bit lst);
         edts_pkg::rsp_type r;
         r.status = st; r.key_id_res = key; r.score = sc[edts_pkg::SCORE_W-1:0]; r.last = lst;
         owed_hits = {owed_hits, r};
      endfunction

      function void close_row(bit [15:0] key);
         logic [2:0] e;
         e = 0;
         if (rows >= N_ROWS || key == 0) e = edts_pkg::ST_INVALID;
         else begin
            for (int r = 0; r < rows; r++)
               if (keys[r] == key) begin
                  e = edts_pkg::ST_DUP;
                  break;
               end
            if (e == 0) begin
               if (elems > N_DIM || (rows > 0 && elems != dim)) e = edts_pkg::ST_DIM;
               else if (!unit_norm(sqsum)) e = edts_pkg::ST_INVALID;
            end
         end
         if (e != 0) berr = e;
         else begin
            if (rows == 0) dim = elems;
            keys[rows] = key;
            rows++;
         end
         elems = 0;
         sqsum = 0;
      endfunction

      function void score_query(int n, int kin);
         int     kk, found, j;
         longint qs, acc;
         longint bs [N_K];
         bit [15:0] bk [N_K];
         kk = (kin > N_K) ? N_K : kin;
         found = 0;
         qs = 0;
         if (kk == 0 || building || rows == 0) begin
            emit(edts_pkg::ST_EMPTY, 0, 0, 1);
            return;
         end
         if (n != dim) begin
            emit(edts_pkg::ST_DIM, 0, 0, 1);
            return;
         end
         for (int i = 0; i < n; i++) qs += longint'($signed(qbuf[i])) * $signed(qbuf[i]);
         if (!unit_norm(qs)) begin
            emit(edts_pkg::ST_INVALID, 0, 0, 1);
            return;
         end
         for (int r = 0; r < rows; r++) begin
            if (any_allowed && !allowed[r]) continue;
            acc = 0;
            for (int i = 0; i < n; i++)
               acc += longint'($signed(qbuf[i])) * $signed(vstore[r*N_DIM+i]);
            if (acc > 64'sd34359738367) acc = 64'sd34359738367;
            if (acc < -64'sd34359738368) acc = -64'sd34359738368;
            for (j = 0; j < found; j++)
               if (acc > bs[j] || (acc == bs[j] && keys[r] < bk[j])) break;
            if (j >= kk) continue;
            if (found < kk) found++;
            for (int i = found - 1; i > j; i--) begin
               bs[i] = bs[i-1];
               bk[i] = bk[i-1];
            end
            bs[j] = acc;
            bk[j] = keys[r];
         end
         if (found == 0) emit(edts_pkg::ST_EMPTY, 0, 0, 1);
         else for (int i = 0; i < found; i++)
            emit(edts_pkg::ST_CAND, bk[i], bs[i], i + 1 == found);
      endfunction

      // an accepted input item moves the predicted state on
      function void note_item(edts_pkg::req_type q);
         longint v;
         int n;
         v = $signed(q.value);
         case (q.op)
            edts_pkg::OP_BEGIN: begin
               building = 1; rows = 0; dim = 0; elems = 0; berr = 0; sqsum = 0;
               clear_allow();
            end
            edts_pkg::OP_ELEM: begin
               if (building && berr == 0) begin
                  if (elems < N_DIM && rows < N_ROWS) vstore[rows*N_DIM+elems] = q.value;
                  sqsum += v * v;
                  if (elems <= N_DIM) elems++;
                  if (q.end_of_vector) close_row(q.key_id);
               end
            end
            edts_pkg::OP_END: begin
               if (!building) emit(edts_pkg::ST_INVALID, 0, 0, 1);
               else begin
                  building = 0;
                  if (berr == 0 && elems != 0) berr = edts_pkg::ST_DIM;
                  if (berr != 0) begin
                     emit(berr, 0, 0, 1);
                     rows = 0;
                     dim = 0;
                  end else emit(edts_pkg::ST_BUILT, rows[15:0], 0, 1);
                  elems = 0; sqsum = 0; berr = 0;
               end
            end
            edts_pkg::OP_ALLOW: begin
               any_allowed = 1;
               if (!building)
                  for (int r = 0; r < rows; r++) if (keys[r] == q.key_id) allowed[r] = 1;
            end
            edts_pkg::OP_QUERY: begin
               if (qcount < N_DIM) qbuf[qcount] = q.value;
               if (qcount <= N_DIM) qcount++;
               if (q.end_of_vector) begin
                  n = qcount;
                  qcount = 0;
                  score_query(n, q.k);
                  clear_allow();
               end
            end
            default: ;
         endcase
      endfunction

      function void check(edts_pkg::rsp_type got);
         edts_pkg::rsp_type want;
         if (owed_hits.size() == 0) begin
            $error("unexpected result item status %0d key %0d", got.status, got.key_id_res);
            errors++;
            return;
         end
         want = owed_hits.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.key_id_res !== want.key_id_res) begin
            $error("key_id_res: expected %0d, got %0d", want.key_id_res, got.key_id_res);
            errors++;
         end
         if (got.score !== want.score) begin
            $error("score: expected %0d, got %0d", want.score, got.score);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   edts_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   edts_pkg::rsp_type rsp_item;

   topk_tracker tracker = new();
   int  cycles = 0;
   int  rsp_gap = 0;
   int  hold_off = 0;     // long receiver stall, counted down below
   bit  no_idle = 0;      // stretch with both sides running flat out
   int  sent = 0;
   int  vec [0:299];
   bit [15:0] used_keys [$];

   exact_dot_topk_search_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always #2 clock = ~clock;

   // cycle count and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: check each accepted result, then draw its next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            tracker.check(rsp_item);
            rsp_gap = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (hold_off > 0) begin
            hold_off = hold_off - 1;
            rsp_ready <= 0;
         end else if (rsp_gap > 0) begin
            rsp_gap = rsp_gap - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // offer one item after a random gap and hold it until taken
   task automatic send(input logic [2:0] op, input logic [15:0] key, input logic [15:0] val,
                       input bit eov, input logic [4:0] kv);
      edts_pkg::req_type q;
      int gap;
      q.op = op; q.key_id = key; q.value = val; q.end_of_vector = eov; q.k = kv;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_item <= q;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(q);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (tracker.owed_hits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // random vector scaled to unit length in q2.14, optionally knocked off the norm
   task automatic make_unit(input int d, input bit spoil);
      real s, f;
      s = 0;
      for (int i = 0; i < d; i++) begin
         vec[i] = $urandom_range(0, 65535) - 32768;
         s += real'(vec[i]) * vec[i];
      end
      if (s == 0) begin
         vec[0] = 1;
         s = 1;
      end
      f = 16384.0 / $sqrt(s);
      for (int i = 0; i < d; i++) vec[i] = $rtoi(vec[i] * f + (vec[i] >= 0 ? 0.5 : -0.5));
      if (spoil) vec[0] = vec[0] + (vec[0] >= 0 ? -3000 : 3000);
   endtask

   // stream vec[0..d-1]; the closing element carries key and k
   task automatic send_vec(input logic [2:0] op, input int d, input logic [15:0] key,
                           input logic [4:0] kv);
      for (int i = 0; i < d; i++)
         send(op, (i == d - 1) ? key : 16'($urandom), 16'(vec[i]), i == d - 1,
              (i == d - 1) ? kv : 5'($urandom));
   endtask

   task automatic row(input int d, input logic [15:0] key, input bit spoil);
      make_unit(d, spoil);
      send_vec(edts_pkg::OP_ELEM, d, key, 0);
      used_keys = {used_keys, key};
   endtask

   task automatic query(input int d, input logic [4:0] kv, input bit spoil);
      make_unit(d, spoil);
      send_vec(edts_pkg::OP_QUERY, d, 16'($urandom), kv);
   endtask

   // random build of a few rows, some of them broken on purpose
   task automatic random_build();
      int nr, d;
      bit [15:0] key;
      nr = $urandom_range(1, 5);
      d = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(1, 6);
      used_keys.delete();
      send(edts_pkg::OP_BEGIN, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
           5'($urandom));
      for (int r = 0; r < nr; r++) begin
         key = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 12)) : 16'($urandom);
         if ($urandom_range(0, 19) == 0) key = 0;
         if ($urandom_range(0, 19) == 0) row(d + 1, key, 0);
         else row(d, key, $urandom_range(0, 19) == 0);
      end
      if ($urandom_range(0, 19) == 0) send(edts_pkg::OP_ELEM, 1, 16'($urandom), 0, 0);
      send(edts_pkg::OP_END, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
           5'($urandom));
      for (int qn = $urandom_range(1, 3); qn > 0; qn--) begin
         for (int a = $urandom_range(0, 3); a > 0; a--)
            send(edts_pkg::OP_ALLOW, (used_keys.size() > 0 && $urandom_range(0, 3) != 0) ?
                 used_keys[$urandom_range(0, used_keys.size() - 1)] : 16'($urandom),
                 16'($urandom), 1'($urandom_range(0, 1)), 5'($urandom));
         query(($urandom_range(0, 9) == 0) ? d + 1 : d,
               ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)),
               $urandom_range(0, 14) == 0);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // end build with no build open, query against an empty index
      send(edts_pkg::OP_END, 0, 0, 1, 0);
      query(2, 1, 0);
      // empty build is accepted with zero rows
      send(edts_pkg::OP_BEGIN, 0, 0, 0, 0);
      send(edts_pkg::OP_END, 0, 0, 0, 0);
      // two orthogonal rows at the key extremes
      send(edts_pkg::OP_BEGIN, 0, 0, 0, 0);
      vec[0] = 16384; vec[1] = 0;
      send_vec(edts_pkg::OP_ELEM, 2, 16'hFFFF, 0);
      vec[0] = 0; vec[1] = -16384;
      send_vec(edts_pkg::OP_ELEM, 2, 16'h0001, 0);
      send(edts_pkg::OP_END, 0, 0, 0, 0);
      send(edts_pkg::OP_ALLOW, 16'h0001, 0, 0, 0);
      send_vec(edts_pkg::OP_QUERY, 2, 0, 5'd31);    // k above the cap
      vec[0] = 16384; vec[1] = 0;
      send_vec(edts_pkg::OP_QUERY, 2, 0, 5'd0);     // k of zero
      send_vec(edts_pkg::OP_QUERY, 1, 0, 5'd1);     // wrong length
      vec[0] = -32768; vec[1] = 32767;
      send_vec(edts_pkg::OP_QUERY, 2, 0, 5'd2);     // norm far off one
      send(edts_pkg::OP_ALLOW, 16'h1234, 0, 0, 0);  // allowed key matching no row
      query(2, 4, 0);
      // empty key, duplicate key, length change, unfinished row, query inside a build
      send(edts_pkg::OP_BEGIN, 0, 0, 0, 0);
      row(2, 0, 0);
      send(edts_pkg::OP_END, 0, 0, 0, 0);
      send(edts_pkg::OP_BEGIN, 0, 0, 0, 0);
      row(2, 5, 0);
      row(2, 5, 0);
      send(edts_pkg::OP_END, 0, 0, 0, 0);
      send(edts_pkg::OP_BEGIN, 0, 0, 0, 0);
      row(2, 6, 0);
      row(3, 7, 0);
      query(2, 1, 0);
      send(edts_pkg::OP_ELEM, 0, 16'h7FFF, 0, 0);
      send(edts_pkg::OP_END, 0, 0, 0, 0);
      drain();

      // random part: mostly well-formed builds and queries, some noise
      while (sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) != 0) begin
            random_build();
         end else begin
            for (int n = $urandom_range(1, 6); n > 0; n--)
               send(3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                    5'($urandom));
         end
         if ($urandom_range(0, 5) == 0) drain();
      end

      // receiver holds off while the sender keeps a full build and query flowing
      no_idle = 0;
      send(edts_pkg::OP_BEGIN, 0, 0, 0, 0);
      for (int r = 0; r < 8; r++) row(4, 16'(100 + r), 0);
      send(edts_pkg::OP_END, 0, 0, 0, 0);
      hold_off = 600;
      query(4, 16, 0);
      query(4, 16, 0);
      query(4, 3, 0);

      req_valid <= 0;
      while (tracker.owed_hits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed_hits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/edts_pkg.sv
hdl/edts_store.sv
hdl/edts_topk.sv
hdl/exact_dot_topk_search_unit.sv
hdl/edts_sva.sv
sim/exact_dot_topk_search_unit_tb.sv
